@@ hdl/sdspi_pkg.sv @@
// ----------------------------------------------------------------------------
// SD SPI command engine package
// Shared constants, codes and a helper function for the command sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    // Longest response that is ever collected, in bytes.
    localparam int unsigned RESP_BYTES_MAX = 5;
    localparam int unsigned RESP_W         = 8 * RESP_BYTES_MAX;

    // Input transfer layout (tdata, lowest bit first).
    localparam int unsigned IN_DATA_W  = 56;
    // Output transfer layout (tdata, lowest bit first).
    localparam int unsigned OUT_DATA_W = 56;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_POLL_LIMIT = 1'b0;
    localparam logic [7:0]  POLL_LIMIT_RESET = 8'd64;

    // Input selector codes.
    localparam logic FUNC_START    = 1'b0;
    localparam logic FUNC_EXCHANGE = 1'b1;

    // Frame bytes.
    localparam logic [7:0] CMD_START_BITS = 8'h40;
    localparam logic [7:0] CMD_CRC_BYTE   = 8'h95;
    localparam logic [7:0] IDLE_BYTE      = 8'hFF;
    localparam logic [7:0] MAX_POLLS      = 8'hFF;

    // Response kinds.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_R1      = 3'd1;
    localparam logic [2:0] KIND_R1_BUSY = 3'd2;
    localparam logic [2:0] KIND_R2      = 3'd3;
    localparam logic [2:0] KIND_R3      = 3'd4;

    // Number of response bytes for a response kind, capped at the maximum.
    function automatic logic [2:0] resp_len(input logic [2:0] kind);
        logic [2:0] n;
        case (kind)
            KIND_R1, KIND_R1_BUSY: n = 3'd1;
            KIND_R2:               n = 3'd2;
            KIND_R3:               n = 3'd5;
            default:               n = 3'd0;
        endcase
        if (n > 3'(RESP_BYTES_MAX)) begin
            n = 3'(RESP_BYTES_MAX);
        end
        return n;
    endfunction

endpackage

@@ hdl/sd_spi_command_engine_unit.sv @@
// A transfer accepted into the input register moves on into the result register, and so
// onto the output, once the result register is empty or its result is being taken.
// Throughput: one transfer per cycle, sustained, whenever the output side is ready.
// The input register and the result register each hold one transfer, so the input
// takes one more transfer while a finished result waits, then stalls until it is taken.
// Reset (i_rst_n low, synchronous) empties both registers, idles the sequencer, limit 64.
// ----------------------------------------------------------------------------
// SD card SPI-mode command sequencer
// Sends the six-byte command frame, polls for the response token, collects
// the response bytes and waits out a busy card, one byte exchange per transfer.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Command and exchange stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] cmd_index, [37:6] cmd_arg, [40:38] resp_kind, [48:41] rx_byte
    input  logic [sdspi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] func
    input  logic                                 s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] tx_byte, [8] exchange, [9] chip_select, [10] done_res, [11] ok,
    // [51:12] response
    output logic [sdspi_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sdspi_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // Sequencer phases, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SEND    = 6'b000010,
        PH_POLL    = 6'b000100,
        PH_COLLECT = 6'b001000,
        PH_BUSY    = 6'b010000,
        PH_FINAL   = 6'b100000
    } t_phase;

    // ------------------------------------------------------------------------
    // Configuration register. The register index is paddr[2]; only index zero
    // exists, higher addresses read as zero and ignore writes.
    // ------------------------------------------------------------------------
    logic [7:0] r_poll_limit;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= sdspi_pkg::POLL_LIMIT_RESET;
        end else if (cfg_wr && paddr[2] == sdspi_pkg::REG_POLL_LIMIT) begin
            r_poll_limit <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == sdspi_pkg::REG_POLL_LIMIT) ? {24'd0, r_poll_limit} : 32'd0;

    // ------------------------------------------------------------------------
    // Handshake. The result register moves when it is empty or being taken;
    // the input register moves when it is empty or can hand on its transfer.
    // ------------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic out_ready;
    logic advance;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;
    assign m_axis_tvalid = r_out_valid;

    // Input register: payload only, no reset needed.
    logic        r_in_func;
    logic [5:0]  r_in_idx;
    logic [31:0] r_in_arg;
    logic [2:0]  r_in_kind;
    logic [7:0]  r_in_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= s_axis_tuser;
            r_in_idx  <= s_axis_tdata[5:0];
            r_in_arg  <= s_axis_tdata[37:6];
            r_in_kind <= s_axis_tdata[40:38];
            r_in_rx   <= s_axis_tdata[48:41];
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer state. It is updated only when the transfer in the input
    // register moves into the result register.
    // ------------------------------------------------------------------------
    t_phase                    r_phase,    n_phase;
    logic [31:0]               r_cmd_arg,  n_cmd_arg;
    logic [2:0]                r_byte_cnt, n_byte_cnt;
    logic [7:0]                r_poll_cnt, n_poll_cnt;
    logic [2:0]                r_kind,     n_kind;
    logic [sdspi_pkg::RESP_W-1:0] r_resp,  n_resp;

    // Result fields.
    logic [7:0]                   res_tx;
    logic                         res_exch;
    logic                         res_cs;
    logic                         res_done;
    logic                         res_ok;
    logic [sdspi_pkg::RESP_W-1:0] res_resp;

    logic [2:0] len;
    logic [2:0] send_cnt;
    logic [7:0] poll_next;

    assign len       = sdspi_pkg::resp_len(r_kind);
    assign send_cnt  = r_byte_cnt + 3'd1;
    assign poll_next = (r_poll_cnt < sdspi_pkg::MAX_POLLS) ? r_poll_cnt + 8'd1 : r_poll_cnt;

    always_comb begin
        n_phase    = r_phase;
        n_cmd_arg  = r_cmd_arg;
        n_byte_cnt = r_byte_cnt;
        n_poll_cnt = r_poll_cnt;
        n_kind     = r_kind;
        n_resp     = r_resp;

        // Most exchanges keep the card selected and clock out an idle byte.
        res_tx   = sdspi_pkg::IDLE_BYTE;
        res_exch = 1'b1;
        res_cs   = 1'b1;
        res_done = 1'b0;
        res_ok   = 1'b0;
        res_resp = '0;

        if (r_in_func == sdspi_pkg::FUNC_START) begin
            // A start abandons whatever command was running.
            n_cmd_arg  = r_in_arg;
            n_kind     = r_in_kind;
            n_byte_cnt = 3'd0;
            n_poll_cnt = 8'd0;
            n_resp     = '0;
            n_phase    = PH_SEND;
            res_tx     = sdspi_pkg::CMD_START_BITS | {2'b00, r_in_idx};
        end else begin
            unique case (r_phase)
                PH_SEND: begin
                    if (r_byte_cnt < 3'd4) begin
                        // Argument bytes, most significant first.
                        n_byte_cnt = send_cnt;
                        case (send_cnt)
                            3'd1:    res_tx = r_cmd_arg[31:24];
                            3'd2:    res_tx = r_cmd_arg[23:16];
                            3'd3:    res_tx = r_cmd_arg[15:8];
                            default: res_tx = r_cmd_arg[7:0];
                        endcase
                    end else if (r_byte_cnt == 3'd4) begin
                        n_byte_cnt = 3'd5;
                        res_tx     = sdspi_pkg::CMD_CRC_BYTE;
                    end else begin
                        n_phase    = PH_POLL;
                        n_poll_cnt = 8'd0;
                    end
                end
                PH_POLL: begin
                    n_poll_cnt = poll_next;
                    if (r_in_rx[7] && poll_next < r_poll_limit) begin
                        // Still no response token; keep polling.
                    end else if (poll_next >= r_poll_limit) begin
                        // Out of polls, even if the token came on the last one.
                        n_phase  = PH_IDLE;
                        res_exch = 1'b0;
                        res_cs   = 1'b0;
                        res_done = 1'b1;
                    end else if (len == 3'd0) begin
                        n_phase  = PH_IDLE;
                        res_exch = 1'b0;
                        res_cs   = 1'b0;
                        res_done = 1'b1;
                        res_ok   = 1'b1;
                    end else begin
                        n_resp     = {{(sdspi_pkg::RESP_W-8){1'b0}}, r_in_rx};
                        n_byte_cnt = 3'd1;
                        n_phase    = PH_COLLECT;
                    end
                end
                PH_COLLECT: begin
                    if (r_byte_cnt < len) begin
                        n_resp     = {r_resp[sdspi_pkg::RESP_W-9:0], r_in_rx};
                        n_byte_cnt = send_cnt;
                    end else if (r_kind == sdspi_pkg::KIND_R1_BUSY) begin
                        n_phase = PH_BUSY;
                    end else begin
                        // The byte just received is the trailing byte.
                        n_phase  = PH_IDLE;
                        res_exch = 1'b0;
                        res_cs   = 1'b0;
                        res_done = 1'b1;
                        res_ok   = 1'b1;
                        res_resp = r_resp;
                    end
                end
                PH_BUSY: begin
                    // The card holds the line low while busy.
                    if (r_in_rx == sdspi_pkg::IDLE_BYTE) begin
                        n_phase = PH_FINAL;
                    end
                end
                PH_FINAL: begin
                    n_phase  = PH_IDLE;
                    res_exch = 1'b0;
                    res_cs   = 1'b0;
                    res_done = 1'b1;
                    res_ok   = 1'b1;
                    res_resp = r_resp;
                end
                default: begin
                    // Exchange reports while idle are answered and ignored.
                    n_phase  = PH_IDLE;
                    res_exch = 1'b0;
                    res_cs   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_byte_cnt <= 3'd0;
            r_poll_cnt <= 8'd0;
            r_kind     <= sdspi_pkg::KIND_NONE;
            r_resp     <= '0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_poll_cnt <= n_poll_cnt;
            r_kind     <= n_kind;
            r_resp     <= n_resp;
        end
    end

    // The argument is always loaded by a start before it is used.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_cmd_arg <= n_cmd_arg;
        end
    end

    // ------------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------------
    logic [sdspi_pkg::OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {4'd0, res_resp, res_ok, res_done, res_cs, res_exch, res_tx};
        end
    end

    assign m_axis_tdata = r_out_data;

`ifndef SYNTHESIS
    // A success report always comes with the end of the command.
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[10])
        else $error("ok reported without done");

    // A finished command releases the card and clocks nothing out.
    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> !m_axis_tdata[9] && !m_axis_tdata[8])
        else $error("done reported with select or exchange active");

    // An empty result register never blocks the input.
    a_accept_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // A transfer moved into the result register shows up on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_axis_tvalid)
        else $error("result lost after advance");
`endif

endmodule
